>>> sv/ipv4hc_pkg.sv
// Shared types and constants for the IPv4 receive header checker.
// No dependencies; imported by every module of the block.
package ipv4hc_pkg;

  localparam int unsigned MinHdrBytes = 20;
  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [7:0]  ProtoIcmp   = 8'd1;
  localparam logic [3:0]  VersionV4   = 4'h4;
  localparam logic [15:0] FragMask    = 16'h3fff;
  localparam logic [15:0] CountMax    = 16'hffff;
  localparam logic [15:0] SumGood     = 16'hffff;

  // Header field positions within the datagram
  localparam logic [15:0] PosTotHi  = 16'd2;
  localparam logic [15:0] PosTotLo  = 16'd3;
  localparam logic [15:0] PosFragHi = 16'd6;
  localparam logic [15:0] PosFragLo = 16'd7;
  localparam logic [15:0] PosProto  = 16'd9;
  localparam logic [15:0] PosSrcLo  = 16'd12;
  localparam logic [15:0] PosSrcHi  = 16'd15;

  localparam logic ItemPayload = 1'b0;
  localparam logic ItemVerdict = 1'b1;
  localparam logic TargetTcp   = 1'b0;
  localparam logic TargetIcmp  = 1'b1;

  typedef enum logic [3:0] {
    StOk        = 4'd0,
    StShort     = 4'd1,
    StVersion   = 4'd2,
    StHdrLen    = 4'd3,
    StChecksum  = 4'd4,
    StTotLong   = 4'd5,
    StTotBelow  = 4'd6,
    StFragment  = 4'd7,
    StProtocol  = 4'd8
  } ipv4hc_status_e;

  // One queued work record: an optional payload byte and an optional verdict
  typedef struct packed {
    logic           has_pay;
    logic [7:0]     pay_byte;
    logic           pay_final;
    logic           has_verdict;
    ipv4hc_status_e status;
    logic           target;
    logic [31:0]    src_addr;
  } ipv4hc_op_t;

endpackage

>>> sv/ipv4hc_front.sv
// Front end: accepts datagram bytes, tracks header fields and checksum,
// classifies each byte into a work record. Depends on ipv4hc_pkg.
module ipv4hc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   end_of_packet_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output ipv4hc_pkg::ipv4hc_op_t op_o
);
  import ipv4hc_pkg::*;

  logic [15:0] cnt_q, cnt_d;
  logic [5:0]  hb_q, hb_d;
  logic        vbad_q, vbad_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] tl_q, tl_d;
  logic [15:0] frag_q, frag_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;

  logic        accept;
  logic [15:0] pos;
  logic        vbad_eff;
  logic [5:0]  hb_eff;
  logic [15:0] hb_ext;
  logic        in_hdr;
  logic [15:0] word;
  logic [16:0] raw_sum;
  logic [15:0] sum_new, sum_eff;
  logic [15:0] tl_eff, frag_eff, src_hi_unused;
  logic [7:0]  proto_eff;
  logic [31:0] src_eff;
  logic        pay;
  logic        pay_final;
  logic [15:0] len;
  ipv4hc_status_e status;

  assign src_hi_unused = 16'd0;
  assign accept = in_valid_i && !q_full_i;
  assign pos    = cnt_q;

  always_comb begin
    vbad_eff = (pos == 16'd0) ? (data_byte_i[7:4] != VersionV4) : vbad_q;
    hb_eff   = (pos == 16'd0) ? {data_byte_i[3:0], 2'b00} : hb_q;
    hb_ext   = {10'd0, hb_eff};
    in_hdr   = pos < hb_ext;

    // even positions are high bytes of a header word
    word     = pos[0] ? {8'h00, data_byte_i} : {data_byte_i, 8'h00};
    raw_sum  = {1'b0, sum_q} + {1'b0, word};
    sum_new  = raw_sum[15:0] + {15'd0, raw_sum[16]};
    sum_eff  = in_hdr ? sum_new : sum_q;

    tl_eff    = (pos == PosTotHi || pos == PosTotLo) ? {tl_q[7:0], data_byte_i} : tl_q;
    frag_eff  = (pos == PosFragHi || pos == PosFragLo) ?
                {frag_q[7:0], data_byte_i} : frag_q;
    proto_eff = (pos == PosProto) ? data_byte_i : proto_q;
    src_eff   = (pos >= PosSrcLo && pos <= PosSrcHi) ? {src_q[23:0], data_byte_i} : src_q;

    pay = !vbad_eff && (hb_ext >= 16'(MinHdrBytes)) && (pos != CountMax) &&
          (pos >= hb_ext) && (pos < tl_eff);
    pay_final = (({1'b0, pos} + 17'd1) == {1'b0, tl_eff});

    len = (pos == CountMax) ? CountMax : pos + 16'd1;

    priority if (len < 16'(MinHdrBytes)) begin
      status = StShort;
    end else if (vbad_eff) begin
      status = StVersion;
    end else if (hb_ext < 16'(MinHdrBytes) || hb_ext > len) begin
      status = StHdrLen;
    end else if (sum_eff != SumGood) begin
      status = StChecksum;
    end else if (tl_eff > len) begin
      status = StTotLong;
    end else if (tl_eff < hb_ext) begin
      status = StTotBelow;
    end else if ((frag_eff & FragMask) != 16'd0) begin
      status = StFragment;
    end else if (proto_eff != ProtoTcp && proto_eff != ProtoIcmp) begin
      status = StProtocol;
    end else begin
      status = StOk;
    end
  end

  always_comb begin
    op_o.has_pay     = pay;
    op_o.pay_byte    = data_byte_i;
    op_o.pay_final   = pay_final;
    op_o.has_verdict = end_of_packet_i;
    op_o.status      = status;
    op_o.target      = (status == StOk && proto_eff == ProtoIcmp) ? TargetIcmp : TargetTcp;
    op_o.src_addr    = src_eff | {src_hi_unused, 16'd0};
  end

  assign push_o = accept && (pay || end_of_packet_i);

  always_comb begin
    cnt_d   = cnt_q;
    hb_d    = hb_q;
    vbad_d  = vbad_q;
    sum_d   = sum_q;
    tl_d    = tl_q;
    frag_d  = frag_q;
    proto_d = proto_q;
    src_d   = src_q;
    if (accept) begin
      if (end_of_packet_i) begin
        // datagram done: back to the reset state
        cnt_d   = '0;
        hb_d    = '0;
        vbad_d  = 1'b0;
        sum_d   = '0;
        tl_d    = '0;
        frag_d  = '0;
        proto_d = '0;
        src_d   = '0;
      end else begin
        cnt_d   = len;
        hb_d    = hb_eff;
        vbad_d  = vbad_eff;
        sum_d   = sum_eff;
        tl_d    = tl_eff;
        frag_d  = frag_eff;
        proto_d = proto_eff;
        src_d   = src_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      hb_q    <= '0;
      vbad_q  <= 1'b0;
      sum_q   <= '0;
      tl_q    <= '0;
      frag_q  <= '0;
      proto_q <= '0;
      src_q   <= '0;
    end else begin
      cnt_q   <= cnt_d;
      hb_q    <= hb_d;
      vbad_q  <= vbad_d;
      sum_q   <= sum_d;
      tl_q    <= tl_d;
      frag_q  <= frag_d;
      proto_q <= proto_d;
      src_q   <= src_d;
    end
  end

endmodule

>>> sv/ipv4hc_queue.sv
// Small FIFO of work records between front and back end.
// Depends on ipv4hc_pkg for the record type.
module ipv4hc_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ipv4hc_pkg::ipv4hc_op_t push_op_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   not_empty_o,
  output ipv4hc_pkg::ipv4hc_op_t head_op_o
);
  import ipv4hc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ipv4hc_op_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign not_empty_o = (count_q != '0);
  assign head_op_o   = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

>>> sv/ipv4hc_back.sv
// Back end: expands each work record into one or two result items and
// holds them in the output register. Depends on ipv4hc_pkg.
module ipv4hc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   head_valid_i,
  input  ipv4hc_pkg::ipv4hc_op_t head_op_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   item_kind_o,
  output logic [7:0]             payload_byte_o,
  output logic                   payload_final_o,
  output logic [3:0]             status_o,
  output logic                   target_o,
  output logic [31:0]            source_address_o
);
  import ipv4hc_pkg::*;

  logic        valid_q, valid_d;
  logic        phase_q, phase_d;   // payload half of this record already sent
  logic        kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic        final_q, final_d;
  logic [3:0]  status_q, status_d;
  logic        target_q, target_d;
  logic [31:0] src_q, src_d;
  logic        load;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    valid_d  = valid_q;
    phase_d  = phase_q;
    kind_d   = kind_q;
    byte_d   = byte_q;
    final_d  = final_q;
    status_d = status_q;
    target_d = target_q;
    src_d    = src_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        if (head_op_i.has_pay && !phase_q) begin
          kind_d   = ItemPayload;
          byte_d   = head_op_i.pay_byte;
          final_d  = head_op_i.pay_final;
          status_d = StOk;
          target_d = TargetTcp;
          src_d    = '0;
          if (head_op_i.has_verdict) begin
            phase_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          kind_d   = ItemVerdict;
          byte_d   = '0;
          final_d  = 1'b0;
          status_d = head_op_i.status;
          target_d = head_op_i.target;
          src_d    = head_op_i.src_addr;
          phase_d  = 1'b0;
          pop_o    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    byte_q   <= byte_d;
    final_q  <= final_d;
    status_q <= status_d;
    target_q <= target_d;
    src_q    <= src_d;
  end

  assign out_valid_o      = valid_q;
  assign item_kind_o      = kind_q;
  assign payload_byte_o   = byte_q;
  assign payload_final_o  = final_q;
  assign status_o         = status_q;
  assign target_o         = target_q;
  assign source_address_o = src_q;

endmodule

>>> sv/ipv4_receive_header_checker_unit.sv
// Top level of the IPv4 receive header checker.
// Depends on ipv4hc_pkg, ipv4hc_front, ipv4hc_queue and ipv4hc_back.
//
// The block takes a received IPv4 datagram one byte per transfer, with
// end_of_packet_i high on the last byte of the buffer. It forwards every
// byte whose position lies between the header length and the total length
// as a payload item (item_kind_o = 0, payload_final_o on the last byte
// within total length), version and header length permitting. On the last
// byte it then sends one verdict item (item_kind_o = 1) with the first
// failing check (short, version, header length, checksum, total length too
// long, total length below header length, fragment, protocol), the target
// (TCP or ICMP, meaningful on status OK) and the source address, and
// returns to its reset state for the next datagram. The byte count
// saturates at 65535; nothing past that is forwarded.
// Rate: one byte per cycle while the queue is not full. Each byte is
// classified in the front end in its accept cycle and queued; the back
// end writes one result per cycle into the output register unless the
// output stalls. A byte that yields both a payload item and the verdict
// becomes two result items; the queue absorbs that and output stalls, so
// input stalls only when the QueueDepth-entry queue is full. An accepted
// byte is queued first and then loaded into the output register.
module ipv4_receive_header_checker_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_packet_i,
  // result output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        payload_final_o,
  output logic [3:0]  status_o,
  output logic        target_o,
  output logic [31:0] source_address_o
);
  import ipv4hc_pkg::*;

  ipv4hc_op_t push_op, head_op;
  logic       push, q_full, pop, head_valid;

  // stall only on a full queue, never on input valid
  assign in_stall_o = q_full;

  ipv4hc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .op_o            (push_op)
  );

  ipv4hc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_op_i   (push_op),
    .full_o      (q_full),
    .pop_i       (pop),
    .not_empty_o (head_valid),
    .head_op_o   (head_op)
  );

  ipv4hc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_op_i        (head_op),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .item_kind_o      (item_kind_o),
    .payload_byte_o   (payload_byte_o),
    .payload_final_o  (payload_final_o),
    .status_o         (status_o),
    .target_o         (target_o),
    .source_address_o (source_address_o)
  );

endmodule

>>> tb/testbench.sv
// Testbench for the IPv4 receive header checker: directed and random datagrams
// checked against a byte-level predictor. Depends on ipv4hc_pkg and
// ipv4_receive_header_checker_unit.
`timescale 1ns / 1ps

module testbench;
  import ipv4hc_pkg::*;

  // Generous bound on the run length
  localparam int unsigned CycleLimit = 1_000_000;
  localparam logic [15:0] DfBit      = 16'h4000;
  localparam logic [15:0] MfBit      = 16'h2000;
  localparam logic [7:0]  ProtoUdp   = 8'd17;

  // One result transfer as the block should produce it
  typedef struct packed {
    logic           kind;
    logic [7:0]     pbyte;
    logic           pfinal;
    ipv4hc_status_e status;
    logic           target;
    logic [31:0]    src;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        end_of_packet_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        item_kind_o;
  logic [7:0]  payload_byte_o;
  logic        payload_final_o;
  logic [3:0]  status_o;
  logic        target_o;
  logic [31:0] source_address_o;

  // Traffic shaping, in percent of cycles
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Items the block still owes us, oldest first
  rx_item_t rx_items_q[$];

  // Datagram under construction
  logic [7:0] pkt[$];

  // Predictor copy of the header parse state
  logic [15:0] rx_count;
  logic [5:0]  hdr_bytes;
  logic        bad_version;
  logic [15:0] hdr_sum;
  logic [15:0] tot_len;
  logic [15:0] frag_word;
  logic [7:0]  proto;
  logic [31:0] src_addr;

  ipv4_receive_header_checker_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_packet_i  (end_of_packet_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .item_kind_o      (item_kind_o),
    .payload_byte_o   (payload_byte_o),
    .payload_final_o  (payload_final_o),
    .status_o         (status_o),
    .target_o         (target_o),
    .source_address_o (source_address_o)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_parse();
    rx_count    = '0;
    hdr_bytes   = '0;
    bad_version = 1'b0;
    hdr_sum     = '0;
    tot_len     = '0;
    frag_word   = '0;
    proto       = '0;
    src_addr    = '0;
  endfunction

  // First failing check wins; len is the saturated byte count
  function automatic ipv4hc_status_e datagram_status(input logic [15:0] len);
    if (len < MinHdrBytes) return StShort;
    if (bad_version) return StVersion;
    if (hdr_bytes < MinHdrBytes || hdr_bytes > len) return StHdrLen;
    if (hdr_sum != SumGood) return StChecksum;
    if (tot_len > len) return StTotLong;
    if (tot_len < hdr_bytes) return StTotBelow;
    if ((frag_word & FragMask) != '0) return StFragment;
    if (proto != ProtoTcp && proto != ProtoIcmp) return StProtocol;
    return StOk;
  endfunction

  // Advance the parse by one accepted byte and queue what it should produce
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [15:0] pos;
    logic [16:0] s;
    rx_item_t    it;
    pos = rx_count;
    if (pos == 16'd0) begin
      bad_version = (b[7:4] != VersionV4);
      hdr_bytes   = {b[3:0], 2'b00};
    end
    // end-around carry keeps the one's-complement sum in 16 bits
    if (pos < hdr_bytes) begin
      s       = {1'b0, hdr_sum} + (pos[0] ? {9'h000, b} : {1'b0, b, 8'h00});
      hdr_sum = s[15:0] + {15'h0000, s[16]};
    end
    if (pos == PosTotHi || pos == PosTotLo) tot_len = {tot_len[7:0], b};
    if (pos == PosFragHi || pos == PosFragLo) frag_word = {frag_word[7:0], b};
    if (pos == PosProto) proto = b;
    if (pos >= PosSrcLo && pos <= PosSrcHi) src_addr = {src_addr[23:0], b};

    // payload window: past the header, inside total length, before saturation
    if (!bad_version && hdr_bytes >= MinHdrBytes && pos < CountMax &&
        pos >= hdr_bytes && pos < tot_len) begin
      it        = '0;
      it.kind   = ItemPayload;
      it.pbyte  = b;
      it.pfinal = (pos + 16'd1 == tot_len);
      it.status = StOk;
      rx_items_q.push_back(it);
    end

    if (rx_count != CountMax) rx_count++;

    if (last) begin
      it        = '0;
      it.kind   = ItemVerdict;
      it.status = datagram_status(rx_count);
      it.target = (it.status == StOk && proto == ProtoIcmp) ? TargetIcmp : TargetTcp;
      it.src    = src_addr;
      rx_items_q.push_back(it);
      clear_parse();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, compare every transfer with the oldest item
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    rx_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (rx_items_q.size() == 0) begin
          $error("unexpected result transfer: kind %0d status %0d", item_kind_o, status_o);
          mismatches++;
        end else begin
          want = rx_items_q.pop_front();
          if (item_kind_o !== want.kind) begin
            $error("item_kind: expected %0d, got %0d", want.kind, item_kind_o);
            mismatches++;
          end
          if (payload_byte_o !== want.pbyte) begin
            $error("payload_byte: expected 0x%02h, got 0x%02h", want.pbyte, payload_byte_o);
            mismatches++;
          end
          if (payload_final_o !== want.pfinal) begin
            $error("payload_final: expected %0d, got %0d", want.pfinal, payload_final_o);
            mismatches++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (target_o !== want.target) begin
            $error("target: expected %0d, got %0d", want.target, target_o);
            mismatches++;
          end
          if (source_address_o !== want.src) begin
            $error("source_address: expected 0x%08h, got 0x%08h", want.src,
                   source_address_o);
            mismatches++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Byte side
  // ---------------------------------------------------------------------------

  // One byte transfer; valid stays up afterwards unless the next call idles
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_packet_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_byte(b, last);
  endtask

  task automatic send_packet();
    int unsigned i;
    for (i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Rewrite the checksum field so the header words fold to all ones.
  // Headers shorter than the minimum or longer than the buffer keep theirs.
  function automatic void seal_header();
    int unsigned hb;
    int unsigned s;
    int unsigned i;
    hb = {pkt[0][3:0], 2'b00};
    if (hb < MinHdrBytes || hb > pkt.size()) return;
    pkt[10] = 8'h00;
    pkt[11] = 8'h00;
    s = 0;
    for (i = 0; i < hb; i += 2) s += {pkt[i], pkt[i + 1]};
    while (s > 32'h0000ffff) s = (s & 32'h0000ffff) + (s >> 16);
    {pkt[10], pkt[11]} = ~s[15:0];
  endfunction

  function automatic void truncate(input int unsigned n);
    while (pkt.size() > n) void'(pkt.pop_back());
  endfunction

  // Random-content datagram with the given shape; at least 20 bytes long
  task automatic make_datagram(input int unsigned ihl, input int unsigned plen,
                               input int unsigned pad, input logic [15:0] frag,
                               input logic [7:0] prot);
    int unsigned hb;
    logic [15:0] tot;
    hb  = ihl * 4;
    tot = 16'(hb + plen);
    pkt.delete();
    while (pkt.size() < hb + plen + pad || pkt.size() < MinHdrBytes)
      pkt.push_back(8'($urandom_range(255)));
    pkt[0] = {VersionV4, 4'(ihl)};
    {pkt[2], pkt[3]} = tot;
    {pkt[6], pkt[7]} = frag;
    pkt[9] = prot;
    seal_header();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Clean datagrams: both targets, options, padding, extreme byte values
  task automatic test_valid_datagrams();
    int unsigned i;
    make_datagram(5, 0, 0, 16'h0000, ProtoTcp);   // header only
    send_packet();
    make_datagram(5, 8, 0, DfBit, ProtoIcmp);     // don't-fragment is allowed
    send_packet();
    make_datagram(15, 5, 0, 16'h0000, ProtoTcp);  // maximum options dropped
    send_packet();
    make_datagram(6, 6, 4, DfBit, ProtoTcp);      // trailing padding trimmed
    send_packet();
    make_datagram(5, 4, 0, 16'h8000 | DfBit, ProtoIcmp); // reserved bit ignored
    for (i = 12; i < 16; i++) pkt[i] = 8'hff;
    for (i = 20; i < 24; i++) pkt[i] = 8'h00;
    seal_header();
    send_packet();
    make_datagram(5, 4, 0, 16'h0000, ProtoTcp);
    for (i = 12; i < 16; i++) pkt[i] = 8'h00;
    for (i = 20; i < 24; i++) pkt[i] = 8'hff;
    seal_header();
    send_packet();
  endtask

  // Datagrams for each failing check, in priority order
  task automatic test_header_errors();
    make_datagram(5, 4, 0, 16'h0000, ProtoTcp);   // single byte
    truncate(1);
    send_packet();
    make_datagram(5, 4, 0, 16'h0000, ProtoTcp);   // source half received
    truncate(14);
    send_packet();
    make_datagram(5, 4, 0, 16'h0000, ProtoTcp);   // one byte short
    truncate(19);
    send_packet();
    make_datagram(5, 4, 0, 16'h0000, ProtoTcp);   // version 6
    pkt[0][7:4] = 4'h6;
    seal_header();
    send_packet();
    make_datagram(4, 8, 0, 16'h0000, ProtoTcp);   // header length below minimum
    send_packet();
    make_datagram(15, 0, 0, 16'h0000, ProtoTcp);  // header runs past the buffer
    truncate(40);
    send_packet();
    make_datagram(5, 4, 0, 16'h0000, ProtoTcp);   // bad checksum
    pkt[11] = pkt[11] ^ 8'h01;
    send_packet();
    make_datagram(5, 10, 0, 16'h0000, ProtoTcp);  // total longer than received
    truncate(25);
    send_packet();
    make_datagram(5, 4, 0, 16'h0000, ProtoTcp);   // total below header length
    {pkt[2], pkt[3]} = 16'd12;
    seal_header();
    send_packet();
    make_datagram(5, 4, 0, MfBit, ProtoTcp);      // more fragments
    send_packet();
    make_datagram(5, 4, 0, 16'h0001, ProtoIcmp);  // nonzero offset
    send_packet();
    make_datagram(5, 4, 0, 16'h0000, ProtoUdp);   // unsupported protocol
    send_packet();
    make_datagram(5, 4, 0, 16'h0000, 8'h00);
    send_packet();
  endtask

  // Mostly well-formed datagrams, some broken
  task automatic random_datagram();
    int unsigned ihl;
    int unsigned plen;
    int unsigned pad;
    logic [15:0] frag;
    logic [7:0]  prot;
    logic [3:0]  ver;
    ihl  = ($urandom_range(3) == 0) ? $urandom_range(6, 15) : 5;
    plen = $urandom_range(0, 24);
    pad  = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
    frag = ($urandom_range(7) != 0) ? {1'($urandom_range(1)), 1'($urandom_range(1)), 14'h0}
                                    : 16'($urandom);
    prot = ($urandom_range(7) != 0) ? (($urandom_range(1) == 1) ? ProtoTcp : ProtoIcmp)
                                    : 8'($urandom_range(255));
    make_datagram(ihl, plen, pad, frag, prot);
    case ($urandom_range(9))
      0: truncate($urandom_range(1, pkt.size() - 1));
      1: begin
        do ver = 4'($urandom_range(15)); while (ver == VersionV4);
        pkt[0][7:4] = ver;
        seal_header();
      end
      2: pkt[10] = pkt[10] ^ 8'($urandom_range(1, 255));
      3: pkt[0][3:0] = 4'($urandom_range(4));
      4: begin
        {pkt[2], pkt[3]} = 16'($urandom_range(0, pkt.size() + 8));
        seal_header();
      end
      default: ;
    endcase
  endtask

  task automatic test_random_traffic(input int unsigned n_bytes, input int unsigned idle,
                                     input int unsigned stall);
    int unsigned sent;
    int unsigned n;
    int unsigned i;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(19) == 0) begin
        // noise burst, closed with an end mark so the next datagram is aligned
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
          send_byte(8'($urandom_range(255)), (i == n - 1) || ($urandom_range(3) == 0));
      end else begin
        random_datagram();
        send_packet();
        sent += pkt.size();
      end
    end
  endtask

  initial begin
    clear_parse();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_valid_datagrams();
    test_header_errors();
    test_random_traffic(200, 0, 0);
    test_random_traffic(200, 58, 0);
    test_random_traffic(200, 0, 58);
    test_random_traffic(200, 8, 8);
    in_valid_i <= 1'b0;

    // drain, then wait on to catch stray transfers
    while (rx_items_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
sv/ipv4hc_pkg.sv
sv/ipv4hc_front.sv
sv/ipv4hc_queue.sv
sv/ipv4hc_back.sv
sv/ipv4_receive_header_checker_unit.sv
tb/testbench.sv
